FILE: hdl/tnzd_pkg.sv
// Package for the near-zero dither unit: configuration and command types,
// hash constants and the single-precision add/multiply/round helpers.
// No dependencies.
`timescale 1ns / 1ps

package tnzd_pkg;

    localparam int INDEX_BITS = 32;
    localparam int DIM_BITS   = 16;

    // dither mode codes
    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_CHK_NCHW   = 3'd1;
    localparam logic [2:0] MODE_CHK_NHWC   = 3'd2;
    localparam logic [2:0] MODE_RAND_NCHW  = 3'd3;
    localparam logic [2:0] MODE_RAND_NHWC  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_OFS_LOW  = 3'd1;
    localparam logic [2:0] REG_OFS_HIGH = 3'd2;
    localparam logic [2:0] REG_LIMIT    = 3'd3;
    localparam logic [2:0] REG_SEED     = 3'd4;
    localparam logic [2:0] REG_CHANNELS = 3'd5;
    localparam logic [2:0] REG_HEIGHT   = 3'd6;
    localparam logic [2:0] REG_WIDTH    = 3'd7;

    // hash constants
    localparam logic [31:0] K_IDX_HI = 32'h9e3779b9;
    localparam logic [31:0] K_ROW    = 32'h85ebca6b;
    localparam logic [31:0] K_COL    = 32'hc2b2ae35;
    localparam logic [31:0] K_MIX1   = 32'h7feb352d;
    localparam logic [31:0] K_MIX2   = 32'h846ca68b;

    localparam logic [31:0] QNAN_DEFAULT = 32'h7fc00000;
    localparam logic [31:0] QUIET_BIT    = 32'h00400000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] offset_low;
        logic [31:0] offset_high;
        logic [31:0] limit;
        logic [31:0] seed;
        logic [15:0] channels;
        logic [15:0] height;
        logic [15:0] width;
    } cfg_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE, OP_HASH_HI, OP_HASH_Y, OP_HASH_X, OP_MIX1, OP_MIX2, OP_UNIT,
        OP_SPAN_A, OP_ADD_B, OP_MUL_A, OP_MUL_B, OP_DEL_A, OP_DEL_B, OP_SUM_A
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic rand_sel;
    } dp_status_t;

    // adder intermediate between align/add and normalize/round
    typedef struct packed {
        logic        special;
        logic [31:0] spec;
        logic        sign;
        logic [9:0]  exp;
        logic [27:0] mag;
    } add_mid_t;

    // multiplier intermediate between product and normalize/round
    typedef struct packed {
        logic               special;
        logic [31:0]        spec;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        prod;
    } mul_mid_t;

    function automatic logic is_nan(logic [31:0] x);
        return x[30:0] > 31'h7f800000;
    endfunction

    function automatic logic is_inf(logic [31:0] x);
        return x[30:0] == 31'h7f800000;
    endfunction

    function automatic logic [4:0] lzc24(logic [23:0] m);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(logic [26:0] m);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (m[i]) n = 5'(26 - i);
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc48(logic [47:0] m);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    // round to nearest even and pack; m[26:3] mantissa, m[2] guard, m[1:0] sticky
    function automatic logic [31:0] round_pack(logic sign, logic [9:0] e, logic [26:0] m);
        logic        up;
        logic [24:0] r;
        logic [9:0]  field;
        logic [22:0] frac;
        up = m[2] & ((|m[1:0]) | m[3]);
        r  = {1'b0, m[26:3]} + 25'(up);
        if (r[24]) begin
            field = e + 10'd1;
            frac  = 23'd0;
        end else begin
            field = r[23] ? e : 10'd0;
            frac  = r[22:0];
        end
        if (field >= 10'd255) return {sign, 8'hff, 23'd0};
        return {sign, field[7:0], frac};
    endfunction

    // add front half: specials, swap, align, add
    function automatic add_mid_t fadd_pre(logic [31:0] a, logic [31:0] b, logic sub);
        add_mid_t    r;
        logic [31:0] bx, big, sml;
        logic [7:0]  eb, es, d;
        logic [26:0] mb, ms, al;
        logic [27:0] sum;
        r   = '0;
        bx  = sub ? {~b[31], b[30:0]} : b;
        big = (b[30:0] > a[30:0]) ? bx : a;
        sml = (b[30:0] > a[30:0]) ? a : bx;
        eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb  = {big[30:23] != 8'd0, big[22:0], 3'b000};
        ms  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
        d   = eb - es;
        if (d >= 8'd27) begin
            al = {26'd0, |ms};
        end else begin
            al = (ms >> d) | 27'(|(ms & ((27'd1 << d) - 27'd1)));
        end
        sum = (big[31] == sml[31]) ? ({1'b0, mb} + {1'b0, al}) : ({1'b0, mb} - {1'b0, al});
        if (is_nan(a)) begin
            r.special = 1'b1;
            r.spec    = a | QUIET_BIT;
        end else if (is_nan(b)) begin
            r.special = 1'b1;
            r.spec    = b | QUIET_BIT;
        end else if (is_inf(a) && is_inf(bx) && (a[31] != bx[31])) begin
            r.special = 1'b1;
            r.spec    = QNAN_DEFAULT;
        end else if (is_inf(a)) begin
            r.special = 1'b1;
            r.spec    = a;
        end else if (is_inf(bx)) begin
            r.special = 1'b1;
            r.spec    = bx;
        end else if (sum == 28'd0) begin
            // exact zero: negative only when both operands are negative
            r.special = 1'b1;
            r.spec    = {big[31] & sml[31], 31'd0};
        end else begin
            r.sign = big[31];
            r.exp  = 10'(eb);
            r.mag  = sum;
        end
        return r;
    endfunction

    // add back half: normalize and round
    function automatic logic [31:0] fadd_post(add_mid_t x);
        logic [4:0]  lz;
        logic [9:0]  sh;
        logic [26:0] m;
        logic [9:0]  e;
        lz = lzc27(x.mag[26:0]);
        sh = (10'(lz) < x.exp - 10'd1) ? 10'(lz) : x.exp - 10'd1;
        if (x.mag[27]) begin
            m = {x.mag[27:2], x.mag[1] | x.mag[0]};
            e = x.exp + 10'd1;
        end else begin
            m = x.mag[26:0] << sh;
            e = x.exp - sh;
        end
        if (x.special) return x.spec;
        return round_pack(x.sign, e, m);
    endfunction

    // multiply front half: specials and mantissa product
    function automatic mul_mid_t fmul_pre(logic [31:0] a, logic [31:0] b);
        mul_mid_t   r;
        logic       az, bz, s;
        logic [7:0] ea, eb;
        s  = a[31] ^ b[31];
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        r.special = 1'b1;
        r.spec    = {s, 31'd0};
        r.sign    = s;
        r.exp     = $signed(11'(ea)) + $signed(11'(eb)) - 11'sd127;
        r.prod    = 48'({a[30:23] != 8'd0, a[22:0]}) * 48'({b[30:23] != 8'd0, b[22:0]});
        if (is_nan(a)) begin
            r.spec = a | QUIET_BIT;
        end else if (is_nan(b)) begin
            r.spec = b | QUIET_BIT;
        end else if ((is_inf(a) && bz) || (az && is_inf(b))) begin
            r.spec = QNAN_DEFAULT;
        end else if (is_inf(a) || is_inf(b)) begin
            r.spec = {s, 8'hff, 23'd0};
        end else if (!(az || bz)) begin
            r.special = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [47:0] shr_sticky48(logic [47:0] p, logic [10:0] amt);
        logic [47:0] r;
        if (amt >= 11'd48) begin
            r = {47'd0, |p};
        end else begin
            r = p >> amt;
            r[0] = r[0] | (|(p & ((48'd1 << amt) - 48'd1)));
        end
        return r;
    endfunction

    // multiply back half: normalize (with subnormal range) and round
    function automatic logic [31:0] fmul_post(mul_mid_t x);
        logic [5:0]         lz;
        logic [47:0]        q;
        logic signed [10:0] ee;
        lz = lzc48(x.prod);
        if ($signed(11'(lz)) <= x.exp) begin
            q  = x.prod << lz;
            ee = x.exp + 11'sd1 - $signed(11'(lz));
        end else if (x.exp >= 11'sd0) begin
            q  = x.prod << x.exp[5:0];
            ee = 11'sd1;
        end else begin
            q  = shr_sticky48(x.prod, 11'(-x.exp));
            ee = 11'sd1;
        end
        if (x.special) return x.spec;
        return round_pack(x.sign, 10'(ee), {q[47:24], q[23], q[22], |q[21:0]});
    endfunction

    // counter step: {wrap, next position}
    function automatic logic [DIM_BITS:0] bump(logic [DIM_BITS-1:0] pos, logic [15:0] dim);
        logic [DIM_BITS-1:0] nxt;
        nxt = pos + DIM_BITS'(1);
        if (nxt == '0 || 16'(nxt) >= dim) return {1'b1, {DIM_BITS{1'b0}}};
        return {1'b0, nxt};
    endfunction

endpackage

FILE: hdl/tnzd_ctrl.sv
// Sequencer for the near-zero dither unit: walks one item through the hash,
// float and output steps of the datapath. Depends on tnzd_pkg.
`timescale 1ns / 1ps

module tnzd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    output logic                m_tvalid,
    input  tnzd_pkg::dp_status_t status,
    output tnzd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_HASH_HI = 16'h0002,
        ST_HASH_Y  = 16'h0004,
        ST_HASH_X  = 16'h0008,
        ST_MIX1    = 16'h0010,
        ST_MIX2    = 16'h0020,
        ST_UNIT    = 16'h0040,
        ST_SPAN_A  = 16'h0080,
        ST_SPAN_B  = 16'h0100,
        ST_MUL_A   = 16'h0200,
        ST_MUL_B   = 16'h0400,
        ST_DEL_A   = 16'h0800,
        ST_DEL_B   = 16'h1000,
        ST_SUM_A   = 16'h2000,
        ST_SUM_B   = 16'h4000,
        ST_DONE    = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and datapath command
    always_comb begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.op       = tnzd_pkg::OP_IDLE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (!status.hit)        state_next = ST_DONE;
                    else if (status.rand_sel) state_next = ST_HASH_HI;
                    else                    state_next = ST_SUM_A;
                end
            end
            ST_HASH_HI: begin cmd.op = tnzd_pkg::OP_HASH_HI; state_next = ST_HASH_Y; end
            ST_HASH_Y:  begin cmd.op = tnzd_pkg::OP_HASH_Y;  state_next = ST_HASH_X; end
            ST_HASH_X:  begin cmd.op = tnzd_pkg::OP_HASH_X;  state_next = ST_MIX1;   end
            ST_MIX1:    begin cmd.op = tnzd_pkg::OP_MIX1;    state_next = ST_MIX2;   end
            ST_MIX2:    begin cmd.op = tnzd_pkg::OP_MIX2;    state_next = ST_UNIT;   end
            ST_UNIT:    begin cmd.op = tnzd_pkg::OP_UNIT;    state_next = ST_SPAN_A; end
            ST_SPAN_A:  begin cmd.op = tnzd_pkg::OP_SPAN_A;  state_next = ST_SPAN_B; end
            ST_SPAN_B:  begin cmd.op = tnzd_pkg::OP_ADD_B;   state_next = ST_MUL_A;  end
            ST_MUL_A:   begin cmd.op = tnzd_pkg::OP_MUL_A;   state_next = ST_MUL_B;  end
            ST_MUL_B:   begin cmd.op = tnzd_pkg::OP_MUL_B;   state_next = ST_DEL_A;  end
            ST_DEL_A:   begin cmd.op = tnzd_pkg::OP_DEL_A;   state_next = ST_DEL_B;  end
            ST_DEL_B:   begin cmd.op = tnzd_pkg::OP_DEL_B;   state_next = ST_SUM_A;  end
            ST_SUM_A:   begin cmd.op = tnzd_pkg::OP_SUM_A;   state_next = ST_SUM_B;  end
            ST_SUM_B:   begin cmd.op = tnzd_pkg::OP_ADD_B;   state_next = ST_DONE;   end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)  out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/tnzd_datapath.sv
// Datapath of the near-zero dither unit: position counters, hash with one
// shared 32x32 multiplier, two-step float adder and multiplier, output register.
// Depends on tnzd_pkg.
`timescale 1ns / 1ps

module tnzd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tnzd_pkg::cfg_t       cfg,
    input  logic [31:0]          sample_in,
    input  logic                 tensor_start,
    input  tnzd_pkg::dp_cmd_t    cmd,
    output tnzd_pkg::dp_status_t status,
    output logic [31:0]          sample_out,
    output logic                 was_changed
);

    localparam int DB = tnzd_pkg::DIM_BITS;
    localparam int IB = tnzd_pkg::INDEX_BITS;

    // position state
    logic [IB-1:0] idx_reg, idx_next;
    logic [DB-1:0] row_reg, row_next, col_reg, col_next, chan_reg, chan_next;
    logic [IB-1:0] idx_cur;
    logic [DB-1:0] row_cur, col_cur, chan_cur;
    logic [DB:0]   row_b, col_b, chan_b;
    logic          nhwc;

    // per-item registers
    logic [31:0]         sample_reg, delta_reg, unit_reg, fres_reg, v_reg, idx_hi_reg;
    logic [DB-1:0]       row_use_reg, col_use_reg;
    logic                changed_reg;
    tnzd_pkg::add_mid_t  add_reg;
    tnzd_pkg::mul_mid_t  mul_reg;
    logic [31:0]         out_data_reg;
    logic                out_chg_reg;

    // near-zero test and mode decode
    logic        near_zero, mode_on;
    logic [63:0] idx_wide;

    assign mode_on = (cfg.mode == tnzd_pkg::MODE_CHK_NCHW) ||
                     (cfg.mode == tnzd_pkg::MODE_CHK_NHWC) ||
                     (cfg.mode == tnzd_pkg::MODE_RAND_NCHW) ||
                     (cfg.mode == tnzd_pkg::MODE_RAND_NHWC);
    assign nhwc    = (cfg.mode == tnzd_pkg::MODE_CHK_NHWC) ||
                     (cfg.mode == tnzd_pkg::MODE_RAND_NHWC);

    always_comb begin
        if (tnzd_pkg::is_nan({1'b0, sample_in[30:0]}) || tnzd_pkg::is_nan(cfg.limit)) begin
            near_zero = 1'b1;
        end else if (cfg.limit[31]) begin
            // negative threshold only admits zero against a negative zero
            near_zero = (sample_in[30:0] == 31'd0) && (cfg.limit[30:0] == 31'd0);
        end else begin
            near_zero = sample_in[30:0] <= cfg.limit[30:0];
        end
    end

    assign status.hit      = mode_on && near_zero;
    assign status.rand_sel = (cfg.mode == tnzd_pkg::MODE_RAND_NCHW) ||
                             (cfg.mode == tnzd_pkg::MODE_RAND_NHWC);

    // counters as this item sees them, and their advance
    always_comb begin
        idx_cur  = tensor_start ? '0 : idx_reg;
        row_cur  = tensor_start ? '0 : row_reg;
        col_cur  = tensor_start ? '0 : col_reg;
        chan_cur = tensor_start ? '0 : chan_reg;
        row_b    = tnzd_pkg::bump(row_cur, cfg.height);
        col_b    = tnzd_pkg::bump(col_cur, cfg.width);
        chan_b   = tnzd_pkg::bump(chan_cur, cfg.channels);
        idx_next = idx_cur + IB'(1);
        row_next = row_cur;
        col_next = col_cur;
        chan_next = chan_cur;
        if (nhwc) begin
            chan_next = chan_b[DB-1:0];
            if (chan_b[DB]) begin
                col_next = col_b[DB-1:0];
                if (col_b[DB]) row_next = row_b[DB-1:0];
            end
        end else begin
            col_next = col_b[DB-1:0];
            if (col_b[DB]) begin
                row_next = row_b[DB-1:0];
                if (row_b[DB]) chan_next = chan_b[DB-1:0];
            end
        end
        idx_wide = 64'(idx_cur);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            chan_reg <= '0;
        end else if (cmd.load) begin
            idx_reg  <= idx_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            chan_reg <= chan_next;
        end
    end

    // shared hash multiplier, low 32 bits kept
    logic [31:0] mul_a, mul_b, mul_lo, h_final;
    logic [63:0] mul_full;

    always_comb begin
        mul_a = v_reg;
        mul_b = tnzd_pkg::K_MIX1;
        unique case (cmd.op)
            tnzd_pkg::OP_HASH_HI: begin mul_a = idx_hi_reg;        mul_b = tnzd_pkg::K_IDX_HI; end
            tnzd_pkg::OP_HASH_Y:  begin mul_a = 32'(row_use_reg);  mul_b = tnzd_pkg::K_ROW;    end
            tnzd_pkg::OP_HASH_X:  begin mul_a = 32'(col_use_reg);  mul_b = tnzd_pkg::K_COL;    end
            tnzd_pkg::OP_MIX1:    begin mul_a = v_reg ^ (v_reg >> 16); mul_b = tnzd_pkg::K_MIX1; end
            tnzd_pkg::OP_MIX2:    begin mul_a = v_reg ^ (v_reg >> 15); mul_b = tnzd_pkg::K_MIX2; end
            default: ;
        endcase
        mul_full = 64'(mul_a) * 64'(mul_b);
        mul_lo   = mul_full[31:0];
        h_final  = v_reg ^ (v_reg >> 16);
    end

    // hash fraction in [0,1): exact conversion of the top 24 hash bits
    logic [4:0]  u_lz;
    logic [31:0] unit_val;
    logic [23:0] u_norm;
    always_comb begin
        u_lz   = tnzd_pkg::lzc24(h_final[31:8]);
        u_norm = h_final[31:8] << u_lz;
        if (h_final[31:8] == 24'd0) unit_val = 32'd0;
        else unit_val = {1'b0, 8'(8'd126 - 8'(u_lz)), u_norm[22:0]};
    end

    // float operand selection
    logic [31:0] add_a, add_b;
    logic        add_sub;
    always_comb begin
        add_a   = sample_reg;
        add_b   = delta_reg;
        add_sub = 1'b0;
        unique case (cmd.op)
            tnzd_pkg::OP_SPAN_A: begin
                add_a = cfg.offset_high; add_b = cfg.offset_low; add_sub = 1'b1;
            end
            tnzd_pkg::OP_DEL_A: begin
                add_a = cfg.offset_low; add_b = fres_reg;
            end
            default: ;
        endcase
    end

    // per-item work registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg  <= sample_in;
            changed_reg <= status.hit;
            row_use_reg <= row_cur;
            col_use_reg <= col_cur;
            idx_hi_reg  <= idx_wide[63:32];
            v_reg       <= cfg.seed ^ idx_wide[31:0];
            delta_reg   <= (row_cur[0] ^ col_cur[0]) ? cfg.offset_high : cfg.offset_low;
        end
        unique case (cmd.op)
            tnzd_pkg::OP_HASH_HI, tnzd_pkg::OP_HASH_Y, tnzd_pkg::OP_HASH_X:
                v_reg <= v_reg ^ mul_lo;
            tnzd_pkg::OP_MIX1, tnzd_pkg::OP_MIX2:
                v_reg <= mul_lo;
            tnzd_pkg::OP_UNIT:
                unit_reg <= unit_val;
            tnzd_pkg::OP_SPAN_A, tnzd_pkg::OP_DEL_A, tnzd_pkg::OP_SUM_A:
                add_reg <= tnzd_pkg::fadd_pre(add_a, add_b, add_sub);
            tnzd_pkg::OP_ADD_B:
                fres_reg <= tnzd_pkg::fadd_post(add_reg);
            tnzd_pkg::OP_DEL_B:
                delta_reg <= tnzd_pkg::fadd_post(add_reg);
            tnzd_pkg::OP_MUL_A:
                mul_reg <= tnzd_pkg::fmul_pre(fres_reg, unit_reg);
            tnzd_pkg::OP_MUL_B:
                fres_reg <= tnzd_pkg::fmul_post(mul_reg);
            default: ;
        endcase
        // output register
        if (cmd.out_load) begin
            out_data_reg <= changed_reg ? fres_reg : sample_reg;
            out_chg_reg  <= changed_reg;
        end
    end

    assign sample_out  = out_data_reg;
    assign was_changed = out_chg_reg;

endmodule

FILE: hdl/tensor_near_zero_dither_unit.sv
// Near-zero dither unit, one item at a time. A passed-through item goes straight
// to the output register; checkerboard mode runs the two-step sum first, random
// mode the hash, mix, unit, span, multiply, delta and sum steps over the shared
// hash multiplier and float adder. The next item is taken once the result is in
// the output register, which waits while a result is stalled. Reset (aresetn low,
// synchronous) clears counters, control and configuration to defaults.
`timescale 1ns / 1ps

module tensor_near_zero_dither_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] sample_in
    input  logic        s_tuser,     // [0] tensor_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] sample_out
    output logic        m_tuser,     // [0] was_changed
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);

    tnzd_pkg::cfg_t       cfg_reg;
    tnzd_pkg::dp_cmd_t    cmd;
    tnzd_pkg::dp_status_t status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode        <= tnzd_pkg::MODE_OFF;
            cfg_reg.offset_low  <= 32'h322bcc77;
            cfg_reg.offset_high <= 32'h32abcc77;
            cfg_reg.limit       <= 32'h3dcccccd;
            cfg_reg.seed        <= 32'h6d2b79f5;
            cfg_reg.channels    <= 16'd1;
            cfg_reg.height      <= 16'd1;
            cfg_reg.width       <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tnzd_pkg::REG_MODE:     cfg_reg.mode        <= cfg_wr_data[2:0];
                tnzd_pkg::REG_OFS_LOW:  cfg_reg.offset_low  <= cfg_wr_data;
                tnzd_pkg::REG_OFS_HIGH: cfg_reg.offset_high <= cfg_wr_data;
                tnzd_pkg::REG_LIMIT:    cfg_reg.limit       <= cfg_wr_data;
                tnzd_pkg::REG_SEED:     cfg_reg.seed        <= cfg_wr_data;
                tnzd_pkg::REG_CHANNELS: cfg_reg.channels    <= cfg_wr_data[15:0];
                tnzd_pkg::REG_HEIGHT:   cfg_reg.height      <= cfg_wr_data[15:0];
                tnzd_pkg::REG_WIDTH:    cfg_reg.width       <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    tnzd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    tnzd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .sample_in    (s_tdata),
        .tensor_start (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .sample_out   (m_tdata),
        .was_changed  (m_tuser)
    );

    // one item in flight: no second accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in work");

    // a changed result only comes out of a dithering mode
    a_changed_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (cfg_reg.mode != tnzd_pkg::MODE_OFF &&
                                   cfg_reg.mode <= tnzd_pkg::MODE_RAND_NHWC))
        else $error("changed flag set with dithering off");

    // output register is loaded only while no result is stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && m_tvalid) |-> m_tready)
        else $error("pending result overwritten");

endmodule

FILE: bench/tensor_near_zero_dither_unit_test.sv
// Self-checking bench for tensor_near_zero_dither_unit: drives sample streams
// through several dither settings and checks every result against a bit-exact
// software predictor. Depends on tnzd_pkg and the unit RTL.
`timescale 1ns / 1ps

import tnzd_pkg::*;

// Holds the expected output samples and flags and a private copy of the unit's state
class dither_scoreboard;
    logic [2:0]  mode;
    logic [31:0] ofs_low, ofs_high, limit, seed;
    logic [15:0] n_chan, n_rows, n_cols;
    logic [31:0] elem_idx;
    logic [15:0] row_at, col_at, chan_at;
    logic [31:0] want_sample[$];
    logic        want_changed[$];
    int          errors;

    function new();
        mode = MODE_OFF;
        ofs_low = 32'h322bcc77;
        ofs_high = 32'h32abcc77;
        limit = 32'h3dcccccd;
        seed = 32'h6d2b79f5;
        n_chan = 16'd1;
        n_rows = 16'd1;
        n_cols = 16'd1;
        elem_idx = '0;
        row_at = '0;
        col_at = '0;
        chan_at = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_MODE:     mode = val[2:0];
            REG_OFS_LOW:  ofs_low = val;
            REG_OFS_HIGH: ofs_high = val;
            REG_LIMIT:    limit = val;
            REG_SEED:     seed = val;
            REG_CHANNELS: n_chan = val[15:0];
            REG_HEIGHT:   n_rows = val[15:0];
            REG_WIDTH:    n_cols = val[15:0];
        endcase
    endfunction

    static function logic nan_bits(logic [31:0] x);
        return x[30:0] > 31'h7f800000;
    endfunction

    // round an exact value m * 2^e to single precision, nearest even
    static function logic [31:0] round_single(logic sg, logic [127:0] m, int e);
        int p, k, s, fld;
        logic [255:0] q, rem, half;
        if (m == '0) return {sg, 31'd0};
        p = 0;
        for (int i = 0; i < 128; i++) if (m[i]) p = i;
        k = p + e - 23;
        if (k < -149) k = -149;
        s = k - e;
        q = 256'(m);
        if (s <= 0) begin
            q = q << (-s);
        end else begin
            q = 256'(m) >> s;
            rem = 256'(m) - (q << s);
            half = 256'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
        end
        if (q[24]) begin
            q = q >> 1;
            k++;
        end
        fld = q[23] ? k + 150 : 0;
        if (fld >= 255) return {sg, 8'hff, 23'd0};
        return {sg, 8'(fld), q[22:0]};
    endfunction

    static function int lsb_exp(logic [31:0] x);
        return (x[30:23] == 8'd0) ? -149 : int'(x[30:23]) - 150;
    endfunction

    static function logic [23:0] sig_of(logic [31:0] x);
        return {x[30:23] != 8'd0, x[22:0]};
    endfunction

    static function logic [31:0] f_add(logic [31:0] a, logic [31:0] b, logic sub);
        logic [31:0]  bx;
        logic [127:0] ma, mb;
        int           ea, eb, emin;
        if (nan_bits(a)) return a | QUIET_BIT;
        if (nan_bits(b)) return b | QUIET_BIT;
        bx = sub ? {~b[31], b[30:0]} : b;
        if (a[30:0] == 31'h7f800000 && bx[30:0] == 31'h7f800000 && a[31] != bx[31])
            return QNAN_DEFAULT;
        if (a[30:0] == 31'h7f800000) return a;
        if (bx[30:0] == 31'h7f800000) return bx;
        if (a[30:0] == '0 && bx[30:0] == '0) return {a[31] & bx[31], 31'd0};
        if (bx[30:0] == '0) return a;
        if (a[30:0] == '0) return bx;
        ma = 128'(sig_of(a));
        mb = 128'(sig_of(bx));
        ea = lsb_exp(a);
        eb = lsb_exp(bx);
        // far smaller operand only matters as a sticky bit
        if (ea - eb > 60) begin
            mb = 128'd1;
            eb = ea - 60;
        end else if (eb - ea > 60) begin
            ma = 128'd1;
            ea = eb - 60;
        end
        emin = (ea < eb) ? ea : eb;
        ma = ma << (ea - emin);
        mb = mb << (eb - emin);
        if (a[31] == bx[31]) return round_single(a[31], ma + mb, emin);
        if (ma == mb) return 32'd0;
        if (ma > mb) return round_single(a[31], ma - mb, emin);
        return round_single(bx[31], mb - ma, emin);
    endfunction

    static function logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
        logic sg;
        logic az, bz, ai, bi;
        sg = a[31] ^ b[31];
        if (nan_bits(a)) return a | QUIET_BIT;
        if (nan_bits(b)) return b | QUIET_BIT;
        az = a[30:0] == '0;
        bz = b[30:0] == '0;
        ai = a[30:0] == 31'h7f800000;
        bi = b[30:0] == 31'h7f800000;
        if ((ai && bz) || (az && bi)) return QNAN_DEFAULT;
        if (ai || bi) return {sg, 8'hff, 23'd0};
        if (az || bz) return {sg, 31'd0};
        return round_single(sg, 128'(sig_of(a)) * 128'(sig_of(b)), lsb_exp(a) + lsb_exp(b));
    endfunction

    static function logic [31:0] mix32(logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * K_MIX1;
        v = v ^ (v >> 15);
        v = v * K_MIX2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function logic [31:0] hashed_offset();
        logic [31:0] h, frac;
        h = mix32(seed ^ elem_idx ^ (32'(row_at) * K_ROW) ^ (32'(col_at) * K_COL));
        frac = round_single(1'b0, 128'(h[31:8]), -24);
        return f_add(ofs_low, f_mul(f_add(ofs_high, ofs_low, 1'b1), frac), 1'b0);
    endfunction

    static function logic step_pos(ref logic [15:0] pos, input logic [15:0] dim);
        logic [15:0] nxt;
        nxt = pos + 16'd1;
        if (nxt == '0 || nxt >= dim) begin
            pos = '0;
            return 1'b1;
        end
        pos = nxt;
        return 1'b0;
    endfunction

    // accepted input: predict its result and advance the counters
    function void note_input(logic [31:0] smp, logic first);
        logic [31:0] res, mag;
        logic        chg, above;
        if (first) begin
            elem_idx = '0;
            row_at = '0;
            col_at = '0;
            chan_at = '0;
        end
        res = smp;
        chg = 1'b0;
        if (mode >= MODE_CHK_NCHW && mode <= MODE_RAND_NHWC) begin
            mag = {1'b0, smp[30:0]};
            if (nan_bits(mag) || nan_bits(limit)) above = 1'b0;
            else if (limit[31]) above = !(mag == '0 && limit[30:0] == '0);
            else above = mag[30:0] > limit[30:0];
            if (!above) begin
                if (mode <= MODE_CHK_NHWC)
                    res = f_add(smp, ((row_at[0] ^ col_at[0]) == 1'b0) ? ofs_low : ofs_high,
                                1'b0);
                else
                    res = f_add(smp, hashed_offset(), 1'b0);
                chg = 1'b1;
            end
        end
        want_sample.push_back(res);
        want_changed.push_back(chg);
        elem_idx++;
        if (mode == MODE_CHK_NHWC || mode == MODE_RAND_NHWC) begin
            if (step_pos(chan_at, n_chan))
                if (step_pos(col_at, n_cols))
                    void'(step_pos(row_at, n_rows));
        end else begin
            if (step_pos(col_at, n_cols))
                if (step_pos(row_at, n_rows))
                    void'(step_pos(chan_at, n_chan));
        end
    endfunction

    function void check_result(logic [31:0] got, logic got_chg);
        logic [31:0] w;
        logic        wc;
        if (want_sample.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %h/%b", $time, got, got_chg);
            errors++;
            return;
        end
        w = want_sample.pop_front();
        wc = want_changed.pop_front();
        if (got !== w) begin
            $display("%0t: sample_out expected %h actual %h", $time, w, got);
            errors++;
        end
        if (got_chg !== wc) begin
            $display("%0t: was_changed expected %b actual %b", $time, wc, got_chg);
            errors++;
        end
    endfunction
endclass

module tensor_near_zero_dither_unit_test;
    localparam int STALL_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] sample_in
    logic        s_tuser;     // [0] tensor_start
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] sample_out
    logic        m_tuser;     // [0] was_changed
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wr_data;

    dither_scoreboard sb;
    bit idle_off;
    bit hold_req;
    int quiet_cycles;

    tensor_near_zero_dither_unit dut (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: check items, random stalls, one long hold-off on request
    initial begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (hold_req && hold == 0) begin
                hold = 300;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= idle_off || ($urandom_range(99) >= 13);
            end
        end
    end

    // watchdog on cycles without any accepted or delivered item
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic cfg_done();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // present one item and hold it until taken; maybe idle afterwards
    task automatic send_item(logic [31:0] smp, logic first);
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= first;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(smp, first);
        if (!idle_off && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // drain: all results back, then the unit's longest step time
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.want_sample.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_sample(logic [31:0] lim);
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0, 1, 2: v = {v[31], 8'($urandom_range(90, 126)), v[22:0]};
            3:       v = {v[31], 8'($urandom_range(0, 20)), v[22:0]};
            4:       v = {v[31], lim[30:0] + 31'($urandom_range(0, 2)) - 31'd1};
            5: begin
                case ($urandom_range(5))
                    0: v = {v[31], 31'd0};
                    1: v = {v[31], 31'h7f800000};
                    2: v = {v[31], 8'hff, v[22:0] | 23'd1};
                    3: v = {v[31], 8'h00, v[22:0]};
                    4: v = {v[31], 31'h7f7fffff};
                    default: v = {v[31], 31'h00000001};
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    // one setting plus a run of random items
    task automatic run_phase(logic [2:0] md, logic [31:0] lo, logic [31:0] hi,
                             logic [31:0] lim, logic [31:0] sd,
                             logic [15:0] c, logic [15:0] h, logic [15:0] w, int n);
        cfg_write(REG_MODE, 32'(md));
        cfg_write(REG_OFS_LOW, lo);
        cfg_write(REG_OFS_HIGH, hi);
        cfg_write(REG_LIMIT, lim);
        cfg_write(REG_SEED, sd);
        cfg_write(REG_CHANNELS, 32'(c));
        cfg_write(REG_HEIGHT, 32'(h));
        cfg_write(REG_WIDTH, 32'(w));
        cfg_done();
        for (int i = 0; i < n; i++)
            send_item(pick_sample(lim), (i == 0) || ($urandom_range(99) < 4));
        drain();
    endtask

    initial begin
        logic [31:0] pts[20];
        sb = new();
        idle_off = 0;
        hold_req = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes and float special cases, checkerboard 2x3x2
        pts = '{32'h00000000, 32'h80000000, 32'h3dcccccd, 32'h3dccccce, 32'hbdcccccd,
                32'h7f800000, 32'hff800000, 32'h7fc00000, 32'h7f800001, 32'hffffffff,
                32'h00000001, 32'h807fffff, 32'h7f7fffff, 32'h3f800000, 32'h322bcc77,
                32'hb22bcc77, 32'h12345678, 32'h0000ffff, 32'hb2abcc77, 32'h33333333};
        cfg_write(REG_MODE, 32'(MODE_CHK_NCHW));
        cfg_write(REG_CHANNELS, 32'd2);
        cfg_write(REG_HEIGHT, 32'd3);
        cfg_write(REG_WIDTH, 32'd2);
        cfg_done();
        foreach (pts[i]) send_item(pts[i], i == 0);
        send_item(32'h00000000, 1'b1);
        drain();
        // every mode on the directed values, default offsets and threshold
        for (int md = MODE_OFF; md <= MODE_RAND_NHWC; md++) begin
            cfg_write(REG_MODE, 32'(md));
            cfg_done();
            for (int i = 0; i < 5; i++) send_item(pts[$urandom_range(19)], i == 0);
            drain();
        end

        // random settings, extremes included
        run_phase(MODE_RAND_NCHW, 32'h322bcc77, 32'h32abcc77, 32'h3dcccccd, 32'h0,
                  16'd2, 16'd3, 16'd4, 90);
        idle_off = 1;
        run_phase(MODE_CHK_NHWC, 32'h0, 32'hffffffff, 32'h7f800000, 32'hffffffff,
                  16'd3, 16'd2, 16'd2, 90);
        idle_off = 0;
        // hold the result side while items keep coming
        hold_req = 1;
        run_phase(MODE_RAND_NHWC, 32'hffffffff, 32'h0, 32'hffffffff, $urandom,
                  16'd65535, 16'd65535, 16'd65535, 90);
        run_phase(MODE_CHK_NCHW, $urandom, $urandom, 32'h0, $urandom,
                  16'd1, 16'd1, 16'd1, 60);
        run_phase(MODE_RAND_NCHW, 32'h00000001, 32'h7f7fffff, 32'hbf800000, $urandom,
                  16'd1, 16'd65535, 16'd3, 90);
        run_phase(MODE_OFF, 32'h3f800000, 32'h3f800000, 32'h7f7fffff, $urandom,
                  16'd4, 16'd1, 16'd65535, 60);
        run_phase(MODE_RAND_NHWC, {5'b00110, 27'($urandom)}, {5'b00110, 27'($urandom)},
                  32'h3f000000, $urandom, 16'($urandom_range(1, 5)),
                  16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)), 120);
        run_phase(MODE_CHK_NHWC, $urandom, $urandom, 32'h40000000, $urandom,
                  16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                  16'($urandom_range(1, 4)), 90);

        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.want_sample.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: tensor_near_zero_dither_unit.f
hdl/tnzd_pkg.sv
hdl/tnzd_ctrl.sv
hdl/tnzd_datapath.sv
hdl/tensor_near_zero_dither_unit.sv
bench/tensor_near_zero_dither_unit_test.sv
